### rtl/assert_macros.svh
// Assertion helpers; clk and rst_n are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/vpplt_pkg.sv
`default_nettype none
package vpplt_pkg;

    localparam int ADDR_W     = 14;
    localparam int VMEM_BYTES = 1 << ADDR_W;
    localparam int LINE_W     = 9;
    localparam int CIL_W      = 8;
    localparam int ACC_W      = CIL_W + 1;

    localparam int DEF_LINES_IN_FRAME = 262;
    localparam int DEF_CYCLES_IN_LINE = 228;
    localparam int DEF_SHOWN_LINES    = 192;

    typedef enum logic [1:0] {
        OP_PORT_READ  = 2'd0,
        OP_PORT_WRITE = 2'd1,
        OP_ADVANCE    = 2'd2,
        OP_VCOUNT     = 2'd3
    } op_t;

    localparam logic PORT_DATA = 1'b0;
    localparam logic PORT_CTRL = 1'b1;

    localparam logic [1:0] CMD_REG_WRITE = 2'd2;
    localparam logic [3:0] CODE_VMEM_MAX = 4'd2;
    localparam logic [3:0] CODE_COLOR    = 4'd3;

    localparam logic [3:0] REG_MODE0 = 4'd0;
    localparam logic [3:0] REG_MODE1 = 4'd1;
    localparam logic [3:0] REG_LINE  = 4'd10;

    localparam logic [7:0] MODE0_RESET = 8'h36;
    localparam logic [7:0] MODE1_RESET = 8'h80;
    localparam logic [7:0] LINE_RESET  = 8'hFF;

    localparam logic [4:0] STATUS_FILL = 5'h1F;
    localparam logic [7:0] VC_LOW      = 8'hDA;
    localparam logic [7:0] VC_HIGH     = 8'hE5;
    localparam logic [7:0] VC_JUMP     = 8'd6;

    localparam logic [4:0] CHAN_MID  = 5'(8 + 4);
    localparam logic [4:0] CHAN_HIGH = 5'(16 + 8 + 4 + 2);
    localparam logic [4:0] CHAN_FULL = 5'd31;

    typedef struct packed {
        logic [1:0] op;
        logic       port_sel;
        logic [7:0] write_data;
        logic [7:0] cycle_count;
    } item_t;

    typedef struct packed {
        logic [7:0]        read_data;
        logic              vblank_irq;
        logic              line_irq;
        logic              color_written;
        logic [4:0]        color_index;
        logic [15:0]       color_rgb565;
        logic [LINE_W-1:0] line_number;
    } result_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic adv_step;
        logic adv_finish;
        logic rd_finish;
        logic clear_step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       port_sel;
        logic       acc_ge;
        logic       clear_last;
    } dp_status_t;

    function automatic logic [4:0] chan_expand(logic [1:0] c);
        logic [4:0] v;
        case (c)
            2'd0:    v = 5'd0;
            2'd1:    v = CHAN_MID;
            2'd2:    v = CHAN_HIGH;
            default: v = CHAN_FULL;
        endcase
        return v;
    endfunction

    // red 15:11, green 10:6, bit 5 clear, blue 4:0
    function automatic logic [15:0] to_rgb565(logic [7:0] v);
        return {chan_expand(v[1:0]), chan_expand(v[3:2]), 1'b0, chan_expand(v[5:4])};
    endfunction

endpackage
`default_nettype wire

### rtl/vpplt_ram.sv
`default_nettype none
module vpplt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = vpplt_pkg::VMEM_BYTES,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/vpplt_ctrl.sv
`default_nettype none
module vpplt_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire vpplt_pkg::dp_status_t status,
    output vpplt_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_EXEC   = 5'b00100,
        S_RDWAIT = 5'b01000,
        S_ADV    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.op == vpplt_pkg::OP_PORT_READ &&
                    status.port_sel == vpplt_pkg::PORT_DATA)
                begin
                    state_next = S_RDWAIT;
                end
                else if (status.op == vpplt_pkg::OP_ADVANCE)
                begin
                    state_next = S_ADV;
                end
                else
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RDWAIT:
            begin
                cmd.rd_finish = 1'b1;
                cmd.emit      = 1'b1;
                state_next    = S_IDLE;
            end
            S_ADV:
            begin
                if (status.acc_ge)
                begin
                    cmd.adv_step = 1'b1;
                end
                else
                begin
                    cmd.adv_finish = 1'b1;
                    cmd.emit       = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

### rtl/vpplt_datapath.sv
`default_nettype none
`include "assert_macros.svh"
module vpplt_datapath #(
    parameter int LINES_IN_FRAME = vpplt_pkg::DEF_LINES_IN_FRAME,
    parameter int CYCLES_IN_LINE = vpplt_pkg::DEF_CYCLES_IN_LINE,
    parameter int SHOWN_LINES    = vpplt_pkg::DEF_SHOWN_LINES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire vpplt_pkg::item_t                item,
    input  wire vpplt_pkg::ctrl_cmd_t            cmd,
    output vpplt_pkg::dp_status_t                status,
    output logic                                 ram_we,
    output logic [vpplt_pkg::ADDR_W-1:0]         ram_waddr,
    output logic [7:0]                           ram_wdata,
    output logic [vpplt_pkg::ADDR_W-1:0]         ram_raddr,
    input  wire logic [7:0]                      ram_rdata,
    output vpplt_pkg::result_t                   result,
    output logic                                 done
);

    localparam int AW = vpplt_pkg::ADDR_W;
    localparam int LW = vpplt_pkg::LINE_W;
    localparam int CW = vpplt_pkg::CIL_W;
    localparam int XW = vpplt_pkg::ACC_W;
    localparam logic [LW-1:0] LINES_L = LW'(LINES_IN_FRAME);
    localparam logic [LW-1:0] SHOWN_L = LW'(SHOWN_LINES);
    localparam logic [XW-1:0] CYC_X   = XW'(CYCLES_IN_LINE);
    localparam logic [CW-1:0] CYC_C   = CW'(CYCLES_IN_LINE);

    vpplt_pkg::item_t   req_reg, req_next;
    vpplt_pkg::result_t result_reg, result_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [3:0]    code_reg, code_next;
    logic          first_reg, first_next;
    logic [LW-1:0] line_reg, line_next;
    logic [CW-1:0] cil_reg, cil_next;
    logic [XW-1:0] acc_reg, acc_next;
    logic [1:0]    status_reg, status_next;
    logic          vpend_reg, vpend_next;
    logic          lpend_reg, lpend_next;
    logic [7:0]    mode0_reg, mode0_next;
    logic [7:0]    mode1_reg, mode1_next;
    logic [7:0]    linecmp_reg, linecmp_next;
    logic          done_reg;

    logic [7:0]    rd;
    logic          cw;
    logic [4:0]    cidx;
    logic [15:0]   crgb;
    logic [LW-1:0] line_inc;
    logic [LW-1:0] vline;
    logic [7:0]    wd;

    assign wd = req_reg.write_data;

    always_comb
    begin
        req_next     = cmd.load ? item : req_reg;
        addr_next    = addr_reg;
        clr_next     = clr_reg;
        code_next    = code_reg;
        first_next   = first_reg;
        line_next    = line_reg;
        cil_next     = cil_reg;
        acc_next     = acc_reg;
        status_next  = status_reg;
        vpend_next   = vpend_reg;
        lpend_next   = lpend_reg;
        mode0_next   = mode0_reg;
        mode1_next   = mode1_reg;
        linecmp_next = linecmp_reg;
        ram_we       = 1'b0;
        ram_waddr    = addr_reg;
        ram_wdata    = wd;
        rd           = 8'd0;
        cw           = 1'b0;
        cidx         = 5'd0;
        crgb         = 16'd0;

        line_inc = line_reg + 1'b1;
        if (line_inc >= LINES_L)
        begin
            line_inc = '0;
        end

        vline = line_reg;
        if (line_reg > LW'(vpplt_pkg::VC_LOW) && line_reg < LW'(vpplt_pkg::VC_HIGH))
        begin
            vline = line_reg - LW'(vpplt_pkg::VC_JUMP);
        end

        if (cmd.clear_step)
        begin
            clr_next  = clr_reg + 1'b1;
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = 8'd0;
        end

        if (cmd.exec)
        begin
            case (req_reg.op)
                vpplt_pkg::OP_PORT_READ:
                begin
                    // data-port reads finish once the memory has answered
                    if (req_reg.port_sel == vpplt_pkg::PORT_CTRL)
                    begin
                        rd          = {status_reg, 1'b0, vpplt_pkg::STATUS_FILL};
                        status_next = 2'b00;
                        vpend_next  = 1'b0;
                        lpend_next  = 1'b0;
                        first_next  = 1'b1;
                    end
                end
                vpplt_pkg::OP_PORT_WRITE:
                begin
                    if (req_reg.port_sel == vpplt_pkg::PORT_DATA)
                    begin
                        if (code_reg <= vpplt_pkg::CODE_VMEM_MAX)
                        begin
                            ram_we = 1'b1;
                        end
                        else if (code_reg == vpplt_pkg::CODE_COLOR)
                        begin
                            cw   = 1'b1;
                            cidx = addr_reg[4:0];
                            crgb = vpplt_pkg::to_rgb565(wd);
                        end
                        addr_next  = addr_reg + 1'b1;
                        first_next = 1'b1;
                    end
                    else if (first_reg)
                    begin
                        addr_next  = {addr_reg[AW-1:8], wd};
                        first_next = 1'b0;
                    end
                    else
                    begin
                        first_next = 1'b1;
                        addr_next  = {wd[5:0], addr_reg[7:0]};
                        if (wd[7:6] == vpplt_pkg::CMD_REG_WRITE)
                        begin
                            code_next = {wd[5:4], 2'b00};
                            // only the registers the timer looks at are kept
                            unique case (wd[3:0])
                                vpplt_pkg::REG_MODE0: mode0_next   = addr_reg[7:0];
                                vpplt_pkg::REG_MODE1: mode1_next   = addr_reg[7:0];
                                vpplt_pkg::REG_LINE:  linecmp_next = addr_reg[7:0];
                                default: ;
                            endcase
                        end
                        else
                        begin
                            code_next = {2'b00, wd[7:6]};
                        end
                    end
                end
                vpplt_pkg::OP_ADVANCE:
                begin
                    acc_next = {1'b0, cil_reg} + {1'b0, req_reg.cycle_count};
                end
                default:
                begin
                    rd = vline[7:0];
                end
            endcase
        end

        // one line boundary per cycle
        if (cmd.adv_step)
        begin
            acc_next  = acc_reg - CYC_X;
            line_next = line_inc;
            if (line_inc == SHOWN_L)
            begin
                status_next[1] = 1'b1;
                if (mode1_reg[5])
                begin
                    vpend_next = 1'b1;
                end
            end
            if (line_inc == {1'b0, linecmp_reg})
            begin
                status_next[0] = 1'b1;
                if (mode0_reg[4])
                begin
                    lpend_next = 1'b1;
                end
            end
        end

        if (cmd.adv_finish)
        begin
            cil_next = acc_reg[CW-1:0];
        end

        if (cmd.rd_finish)
        begin
            rd         = ram_rdata;
            addr_next  = addr_reg + 1'b1;
            first_next = 1'b1;
        end

        result_next.read_data     = rd;
        result_next.vblank_irq    = vpend_next;
        result_next.line_irq      = lpend_next;
        result_next.color_written = cw;
        result_next.color_index   = cidx;
        result_next.color_rgb565  = crgb;
        result_next.line_number   = line_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg    <= '0;
            clr_reg     <= '0;
            code_reg    <= '0;
            first_reg   <= 1'b1;
            line_reg    <= '0;
            cil_reg     <= '0;
            status_reg  <= '0;
            vpend_reg   <= 1'b0;
            lpend_reg   <= 1'b0;
            mode0_reg   <= vpplt_pkg::MODE0_RESET;
            mode1_reg   <= vpplt_pkg::MODE1_RESET;
            linecmp_reg <= vpplt_pkg::LINE_RESET;
            done_reg    <= 1'b0;
        end
        else
        begin
            addr_reg    <= addr_next;
            clr_reg     <= clr_next;
            code_reg    <= code_next;
            first_reg   <= first_next;
            line_reg    <= line_next;
            cil_reg     <= cil_next;
            status_reg  <= status_next;
            vpend_reg   <= vpend_next;
            lpend_reg   <= lpend_next;
            mode0_reg   <= mode0_next;
            mode1_reg   <= mode1_next;
            linecmp_reg <= linecmp_next;
            done_reg    <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        acc_reg <= acc_next;
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign ram_raddr         = addr_reg;
    assign status.op         = req_reg.op;
    assign status.port_sel   = req_reg.port_sel;
    assign status.acc_ge     = (acc_reg >= CYC_X);
    assign status.clear_last = &clr_reg;
    assign result            = result_reg;
    assign done              = done_reg;

    `ASSERT_NEVER(a_done_twice, done_reg && $past(done_reg), "result strobe held for two cycles")
    `ASSERT_HOLDS(a_line_range, line_reg < LINES_L, "scanline beyond frame")
    `ASSERT_HOLDS(a_cil_range, cil_reg < CYC_C, "line cycle count beyond line length")

endmodule
`default_nettype wire

### rtl/video_processor_ports_and_line_timer_core.sv
// Start accepted to done strobe: writes, status and counter reads pass the execute state,
// data-port reads add a wait state (registered video memory read), and a time advance adds
// an advance state that crosses line boundaries, one boundary per cycle.
// A new request is taken in the cycle its predecessor's result is shown; results cannot stall.
// After reset busy stays high while video memory is cleared, one byte a cycle.
`default_nettype none
module video_processor_ports_and_line_timer_core #(
    parameter int LINES_IN_FRAME = vpplt_pkg::DEF_LINES_IN_FRAME,
    parameter int CYCLES_IN_LINE = vpplt_pkg::DEF_CYCLES_IN_LINE,
    parameter int SHOWN_LINES    = vpplt_pkg::DEF_SHOWN_LINES
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire vpplt_pkg::item_t item,
    output vpplt_pkg::result_t    result,
    output logic                  done
);

    vpplt_pkg::ctrl_cmd_t            cmd;
    vpplt_pkg::dp_status_t           status;
    logic                            ram_we;
    logic [vpplt_pkg::ADDR_W-1:0]    ram_waddr;
    logic [vpplt_pkg::ADDR_W-1:0]    ram_raddr;
    logic [7:0]                      ram_wdata;
    logic [7:0]                      ram_rdata;

    vpplt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    vpplt_datapath #(
        .LINES_IN_FRAME (LINES_IN_FRAME),
        .CYCLES_IN_LINE (CYCLES_IN_LINE),
        .SHOWN_LINES    (SHOWN_LINES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .status    (status),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .result    (result),
        .done      (done)
    );

    vpplt_ram #(
        .WIDTH (8),
        .DEPTH (vpplt_pkg::VMEM_BYTES)
    ) u_vmem (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire

### test/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINES        = vpplt_pkg::DEF_LINES_IN_FRAME;
    localparam int LINE_LEN     = vpplt_pkg::DEF_CYCLES_IN_LINE;
    localparam int SHOWN        = vpplt_pkg::DEF_SHOWN_LINES;
    localparam int RANDOM_ITEMS = 625;
    localparam int CALM_TAIL    = 80;
    localparam int STALL_LIMIT  = 60000;
    localparam int SETTLE       = 8;

    localparam logic [1:0] CMD_VMEM_READ  = 2'd0;
    localparam logic [1:0] CMD_VMEM_WRITE = 2'd1;
    localparam logic [1:0] CMD_COLOR      = 2'd3;

    localparam logic [3:0][4:0] CHAN_LVL = {vpplt_pkg::CHAN_FULL, vpplt_pkg::CHAN_HIGH,
                                            vpplt_pkg::CHAN_MID, 5'd0};

    typedef struct {
        vpplt_pkg::item_t   it;
        bit                 typed;
        vpplt_pkg::result_t want;
    } plan_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    vpplt_pkg::item_t   item;
    vpplt_pkg::result_t result;
    logic               done;

    // shadow of the block's state
    logic [7:0]  vram_img [vpplt_pkg::VMEM_BYTES];
    logic [7:0]  vreg_img [16];
    logic [13:0] host_addr;
    logic [3:0]  host_code;
    logic        latch_empty;
    logic [8:0]  beam_line;
    logic [7:0]  beam_cycles;
    logic [1:0]  flag_bits;
    logic        vblank_due;
    logic        line_due;

    vpplt_pkg::result_t awaited_results [$];
    int                 mismatches;
    int                 issued;
    int                 quiet_cycles;
    bit                 calm;

    video_processor_ports_and_line_timer_core #(
        .LINES_IN_FRAME(LINES),
        .CYCLES_IN_LINE(LINE_LEN),
        .SHOWN_LINES(SHOWN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .result(result),
        .done(done)
    );

    always #6 clk = ~clk;

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic any_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic plan_row_t bus(logic [1:0] op, logic port, logic [7:0] wd,
                                      logic [7:0] cc);
        plan_row_t r;
        r.it.op          = op;
        r.it.port_sel    = port;
        r.it.write_data  = wd;
        r.it.cycle_count = cc;
        r.typed          = 1'b0;
        r.want           = '0;
        return r;
    endfunction

    // fixed expectation, only used before any time has passed
    function automatic plan_row_t pinned(plan_row_t r, logic [7:0] rd, logic cw,
                                         logic [4:0] ci, logic [15:0] rgb);
        r.typed              = 1'b1;
        r.want               = '0;
        r.want.read_data     = rd;
        r.want.color_written = cw;
        r.want.color_index   = ci;
        r.want.color_rgb565  = rgb;
        return r;
    endfunction

    function automatic vpplt_pkg::result_t bus_item_outcome(vpplt_pkg::item_t it);
        vpplt_pkg::result_t r;
        logic [7:0]         b;
        logic [4:0]         ci;
        int                 acc;
        r = '0;
        b = it.write_data;
        case (it.op)
            vpplt_pkg::OP_PORT_READ:
            begin
                if (it.port_sel == vpplt_pkg::PORT_DATA)
                begin
                    r.read_data = vram_img[host_addr];
                    host_addr   = host_addr + 14'd1;
                    latch_empty = 1'b1;
                end
                else
                begin
                    r.read_data = {flag_bits, 1'b0, vpplt_pkg::STATUS_FILL};
                    flag_bits   = '0;
                    vblank_due  = 1'b0;
                    line_due    = 1'b0;
                    latch_empty = 1'b1;
                end
            end
            vpplt_pkg::OP_PORT_WRITE:
            begin
                if (it.port_sel == vpplt_pkg::PORT_DATA)
                begin
                    if (host_code <= vpplt_pkg::CODE_VMEM_MAX)
                    begin
                        vram_img[host_addr] = b;
                    end
                    else if (host_code == vpplt_pkg::CODE_COLOR)
                    begin
                        ci                 = host_addr[4:0];
                        r.color_written    = 1'b1;
                        r.color_index      = ci;
                        r.color_rgb565     = {CHAN_LVL[b[1:0]], CHAN_LVL[b[3:2]], 1'b0,
                                              CHAN_LVL[b[5:4]]};
                    end
                    host_addr   = host_addr + 14'd1;
                    latch_empty = 1'b1;
                end
                else if (latch_empty)
                begin
                    host_addr[7:0] = b;
                    latch_empty    = 1'b0;
                end
                else
                begin
                    latch_empty     = 1'b1;
                    host_addr[13:8] = b[5:0];
                    if (b[7:6] == vpplt_pkg::CMD_REG_WRITE)
                    begin
                        host_code           = {b[5:4], 2'b00};
                        vreg_img[b[3:0]]    = host_addr[7:0];
                    end
                    else
                    begin
                        host_code = {2'b00, b[7:6]};
                    end
                end
            end
            vpplt_pkg::OP_ADVANCE:
            begin
                acc = int'(beam_cycles) + int'(it.cycle_count);
                while (acc >= LINE_LEN)
                begin
                    acc       = acc - LINE_LEN;
                    beam_line = (beam_line == 9'(LINES - 1)) ? 9'd0 : beam_line + 9'd1;
                    if (beam_line == 9'(SHOWN))
                    begin
                        flag_bits[1] = 1'b1;
                        if (vreg_img[vpplt_pkg::REG_MODE1][5]) vblank_due = 1'b1;
                    end
                    if (beam_line == {1'b0, vreg_img[vpplt_pkg::REG_LINE]})
                    begin
                        flag_bits[0] = 1'b1;
                        if (vreg_img[vpplt_pkg::REG_MODE0][4]) line_due = 1'b1;
                    end
                end
                beam_cycles = 8'(acc);
            end
            default:
            begin
                // counter skips back by six lines inside the jump window
                if (beam_line > vpplt_pkg::VC_LOW && beam_line < vpplt_pkg::VC_HIGH)
                    r.read_data = 8'(beam_line - vpplt_pkg::VC_JUMP);
                else
                    r.read_data = beam_line[7:0];
            end
        endcase
        r.vblank_irq  = vblank_due;
        r.line_irq    = line_due;
        r.line_number = beam_line;
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("%0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // drives one request, waits for it to be taken, then records the expectation
    task automatic issue(plan_row_t r);
        int                 gap;
        vpplt_pkg::result_t predicted;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= r.it;
        do @(posedge clk); while (busy);
        predicted = bus_item_outcome(r.it);
        awaited_results.push_back(r.typed ? r.want : predicted);
        issued++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge clk); while (awaited_results.size() != 0);
    endtask

    always @(posedge clk)
    begin : check_out
        vpplt_pkg::result_t want;
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
            begin
                flag_mismatch("result with no request pending", 64'(result), '0);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (result.read_data !== want.read_data)
                    flag_mismatch("read_data", 64'(result.read_data), 64'(want.read_data));
                if (result.vblank_irq !== want.vblank_irq)
                    flag_mismatch("vblank_irq", 64'(result.vblank_irq),
                                  64'(want.vblank_irq));
                if (result.line_irq !== want.line_irq)
                    flag_mismatch("line_irq", 64'(result.line_irq), 64'(want.line_irq));
                if (result.color_written !== want.color_written)
                    flag_mismatch("color_written", 64'(result.color_written),
                                  64'(want.color_written));
                if (result.color_index !== want.color_index)
                    flag_mismatch("color_index", 64'(result.color_index),
                                  64'(want.color_index));
                if (result.color_rgb565 !== want.color_rgb565)
                    flag_mismatch("color_rgb565", 64'(result.color_rgb565),
                                  64'(want.color_rgb565));
                if (result.line_number !== want.line_number)
                    flag_mismatch("line_number", 64'(result.line_number),
                                  64'(want.line_number));
            end
        end
    end

    // covers the memory clear after reset as well
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        plan_row_t   plan [$];
        int          pick;
        int          n;
        int          target;
        logic [13:0] a;
        logic [3:0]  ri;
        logic [1:0]  cmd;
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        item         = '0;
        mismatches   = 0;
        issued       = 0;
        calm         = 1'b0;
        for (int i = 0; i < vpplt_pkg::VMEM_BYTES; i++) vram_img[i] = '0;
        for (int i = 0; i < 16; i++) vreg_img[i] = '0;
        vreg_img[vpplt_pkg::REG_MODE0] = vpplt_pkg::MODE0_RESET;
        vreg_img[vpplt_pkg::REG_MODE1] = vpplt_pkg::MODE1_RESET;
        vreg_img[vpplt_pkg::REG_LINE]  = vpplt_pkg::LINE_RESET;
        host_addr   = '0;
        host_code   = '0;
        latch_empty = 1'b1;
        beam_line   = '0;
        beam_cycles = '0;
        flag_bits   = '0;
        vblank_due  = 1'b0;
        line_due    = 1'b0;

        // counter read ignores the other fields
        plan.push_back(pinned(bus(vpplt_pkg::OP_VCOUNT, vpplt_pkg::PORT_CTRL, 8'hFF, 8'hFF),
                              8'h00, 1'b0, 5'd0, 16'h0));
        plan.push_back(pinned(bus(vpplt_pkg::OP_PORT_READ, vpplt_pkg::PORT_CTRL, 8'hFF, 8'hFF),
                              8'h1F, 1'b0, 5'd0, 16'h0));
        plan.push_back(pinned(bus(vpplt_pkg::OP_PORT_READ, vpplt_pkg::PORT_DATA, 8'h00, 8'h00),
                              8'h00, 1'b0, 5'd0, 16'h0));
        // top address then write: address wraps to zero
        plan.push_back(pinned(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_CTRL, 8'hFF,
                                  8'h00), 8'h00, 1'b0, 5'd0, 16'h0));
        plan.push_back(pinned(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_CTRL,
                                  {CMD_VMEM_WRITE, 6'h3F}, 8'h00), 8'h00, 1'b0, 5'd0, 16'h0));
        plan.push_back(pinned(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_DATA, 8'hA5,
                                  8'hFF), 8'h00, 1'b0, 5'd0, 16'h0));
        plan.push_back(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_CTRL, 8'hFF, 8'h00));
        plan.push_back(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_CTRL,
                           {CMD_VMEM_READ, 6'h3F}, 8'h00));
        plan.push_back(bus(vpplt_pkg::OP_PORT_READ, vpplt_pkg::PORT_DATA, 8'hFF, 8'hFF));
        // colour memory: last entry, then wrap to entry 0
        plan.push_back(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_CTRL, 8'h1F, 8'h00));
        plan.push_back(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_CTRL,
                           {CMD_COLOR, 6'h00}, 8'h00));
        plan.push_back(pinned(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_DATA, 8'hFF,
                                  8'h00), 8'h00, 1'b1, 5'd31, 16'hFFDF));
        plan.push_back(pinned(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_DATA, 8'h00,
                                  8'h00), 8'h00, 1'b1, 5'd0, 16'h0));
        plan.push_back(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_DATA, 8'h39, 8'h00));
        // register writes: vblank enable, line match 2, then a code that stores nothing
        plan.push_back(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_CTRL, 8'h30, 8'h00));
        plan.push_back(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_CTRL,
                           {vpplt_pkg::CMD_REG_WRITE, 2'b00, vpplt_pkg::REG_MODE1}, 8'h00));
        plan.push_back(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_CTRL, 8'h02, 8'h00));
        plan.push_back(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_CTRL,
                           {vpplt_pkg::CMD_REG_WRITE, 2'b00, vpplt_pkg::REG_LINE}, 8'h00));
        plan.push_back(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_CTRL, 8'h77, 8'h00));
        plan.push_back(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_CTRL,
                           {vpplt_pkg::CMD_REG_WRITE, 2'b11, 4'd5}, 8'h00));
        plan.push_back(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_DATA, 8'h5A, 8'h00));
        plan.push_back(bus(vpplt_pkg::OP_ADVANCE, vpplt_pkg::PORT_DATA, 8'h00, 8'h00));
        plan.push_back(bus(vpplt_pkg::OP_ADVANCE, vpplt_pkg::PORT_CTRL, 8'hFF, 8'hFF));
        plan.push_back(bus(vpplt_pkg::OP_ADVANCE, vpplt_pkg::PORT_DATA, 8'h00, 8'hFF));
        plan.push_back(bus(vpplt_pkg::OP_PORT_READ, vpplt_pkg::PORT_CTRL, 8'h00, 8'h00));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i]) issue(plan[i]);
        wait_drained();

        target = issued + RANDOM_ITEMS;
        while (issued < target)
        begin
            calm = (issued >= target - CALM_TAIL);
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                // runs of advances, mostly close to a whole line, to sweep the frame
                n = $urandom_range(1, 8);
                repeat (n)
                    issue(bus(vpplt_pkg::OP_ADVANCE, any_bit(), any_byte(),
                              ($urandom_range(0, 3) != 0) ? 8'($urandom_range(180, 255))
                                                           : any_byte()));
                if (any_bit())
                    issue(bus(vpplt_pkg::OP_VCOUNT, any_bit(), any_byte(), any_byte()));
            end
            else if (pick < 40)
            begin
                issue(bus(vpplt_pkg::OP_VCOUNT, any_bit(), any_byte(), any_byte()));
            end
            else if (pick < 48)
            begin
                issue(bus(vpplt_pkg::OP_PORT_READ, vpplt_pkg::PORT_CTRL, any_byte(),
                          any_byte()));
            end
            else if (pick < 62)
            begin
                a = 14'($urandom_range(0, vpplt_pkg::VMEM_BYTES - 1));
                case ($urandom_range(0, 2))
                    0:       cmd = CMD_VMEM_READ;
                    1:       cmd = CMD_VMEM_WRITE;
                    default: cmd = CMD_COLOR;
                endcase
                issue(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_CTRL, a[7:0], any_byte()));
                issue(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_CTRL, {cmd, a[13:8]},
                          any_byte()));
                n = $urandom_range(1, 6);
                repeat (n)
                    issue(bus(any_bit() ? vpplt_pkg::OP_PORT_WRITE : vpplt_pkg::OP_PORT_READ,
                              vpplt_pkg::PORT_DATA, any_byte(), any_byte()));
            end
            else if (pick < 74)
            begin
                case ($urandom_range(0, 3))
                    0:       ri = vpplt_pkg::REG_MODE0;
                    1:       ri = vpplt_pkg::REG_MODE1;
                    2:       ri = vpplt_pkg::REG_LINE;
                    default: ri = 4'($urandom_range(0, 15));
                endcase
                issue(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_CTRL, any_byte(),
                          any_byte()));
                issue(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_CTRL,
                          {vpplt_pkg::CMD_REG_WRITE, 2'($urandom_range(0, 3)), ri},
                          any_byte()));
                if (any_bit())
                    issue(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_DATA, any_byte(),
                              any_byte()));
            end
            else if (pick < 86)
            begin
                // write a run, then read it back from the same address
                a = 14'($urandom_range(0, vpplt_pkg::VMEM_BYTES - 1));
                n = $urandom_range(1, 4);
                issue(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_CTRL, a[7:0], any_byte()));
                issue(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_CTRL,
                          {CMD_VMEM_WRITE, a[13:8]}, any_byte()));
                repeat (n)
                    issue(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_DATA, any_byte(),
                              any_byte()));
                issue(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_CTRL, a[7:0], any_byte()));
                issue(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_CTRL,
                          {CMD_VMEM_READ, a[13:8]}, any_byte()));
                repeat (n)
                    issue(bus(vpplt_pkg::OP_PORT_READ, vpplt_pkg::PORT_DATA, any_byte(),
                              any_byte()));
            end
            else if (pick < 96)
            begin
                issue(bus(2'($urandom_range(0, 3)), any_bit(), any_byte(), any_byte()));
            end
            else if (pick < 98)
            begin
                // lone control byte leaves the latch half full
                issue(bus(vpplt_pkg::OP_PORT_WRITE, vpplt_pkg::PORT_CTRL, any_byte(),
                          any_byte()));
            end
            else
            begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire
